### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion wrappers for the core RTL. Every macro samples on clk_i
// and holds off while rst_ni is low. Synthesis builds see empty bodies.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks an implication or expression on every clock edge outside reset.
`define BSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition always holds outside reset.
`define BSC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`else

`define BSC_ASSERT(lbl, prop, msg)
`define BSC_ASSERT_ALWAYS(lbl, cond, msg)

`endif

`endif

### rtl/core/bsc_pkg.sv
// ----------------------------------------------------------------------------
// Safety check package
// Types, codes and default sizes shared by the safety check core.
// ----------------------------------------------------------------------------
package bsc_pkg;

  // Default table dimensions.
  localparam int unsigned ProcessesDef = 8;
  localparam int unsigned ResourcesDef = 4;

  // Fixed field widths.
  localparam int unsigned OpW   = 2;
  localparam int unsigned PidW  = 3;
  localparam int unsigned RidW  = 2;
  localparam int unsigned PosW  = 3;
  localparam int unsigned ValW  = 16;
  localparam int unsigned WorkW = 20;

  // Command codes.
  typedef enum logic [OpW-1:0] {
    OP_LOAD_AVAIL = 2'd0,
    OP_LOAD_PROC  = 2'd1,
    OP_CHECK      = 2'd2
  } opcode_e;

  // Operations of the shared work-vector unit.
  typedef enum logic [1:0] {
    WU_IDLE = 2'd0,
    WU_LOAD = 2'd1,
    WU_ADD  = 2'd2
  } wu_op_e;

  // Input transaction.
  typedef struct packed {
    logic [OpW-1:0]  opcode;
    logic [PidW-1:0] process_index;
    logic [RidW-1:0] resource_index;
    logic [ValW-1:0] available_amount;
    logic [ValW-1:0] max_demand;
    logic [ValW-1:0] allocation;
  } bsc_req_t;

  // Result transaction.
  typedef struct packed {
    logic            safe;
    logic [PosW-1:0] position;
    logic [PidW-1:0] process_id;
    logic            last;
  } bsc_rsp_t;

  // Table write strobes from the sequencer.
  typedef struct packed {
    logic wr_avail;
    logic wr_proc;
  } tbl_ctrl_t;

endpackage

### rtl/core/bsc_tables.sv
// ----------------------------------------------------------------------------
// Safety check tables
// Holds the available amounts and a memory of need and allocation per
// process and resource. Need is formed once when an entry is loaded.
// ----------------------------------------------------------------------------
module bsc_tables
  import bsc_pkg::*;
#(
  parameter int unsigned Processes = ProcessesDef,
  parameter int unsigned Resources = ResourcesDef,
  localparam int unsigned PIW = (Processes > 1) ? $clog2(Processes) : 1,
  localparam int unsigned RIW = (Resources > 1) ? $clog2(Resources) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tbl_ctrl_t       ctrl_i,
  input  bsc_req_t        req_i,
  input  logic [PIW-1:0]  rd_p_i,
  input  logic [RIW-1:0]  rd_r_i,
  output logic [ValW-1:0] avail_o,
  output logic [ValW-1:0] need_o,
  output logic [ValW-1:0] held_o
);

  logic [ValW-1:0]                          avail_q [Resources];
  logic [2*ValW-1:0]                        mem [Processes][Resources];
  logic [Processes-1:0][Resources-1:0]      valid_q;
  logic [2*ValW-1:0]                        rd_data_q;
  logic                                     rd_valid_q;
  logic                                     res_ok;
  logic                                     proc_ok;
  logic [PIW-1:0]                           wr_p;
  logic [RIW-1:0]                           wr_r;
  logic [ValW-1:0]                          need_wr;

  // Loads outside the configured dimensions are dropped.
  assign res_ok  = int'(req_i.resource_index) < Resources;
  assign proc_ok = int'(req_i.process_index) < Processes;
  assign wr_p    = PIW'(req_i.process_index);
  assign wr_r    = RIW'(req_i.resource_index);

  // Need is the demand above the allocation, zero when none remains.
  assign need_wr = (req_i.max_demand > req_i.allocation) ?
                   (req_i.max_demand - req_i.allocation) : '0;

  // Available amounts, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Resources; i++) begin
        avail_q[i] <= '0;
      end
    end else if (ctrl_i.wr_avail && res_ok) begin
      avail_q[wr_r] <= req_i.available_amount;
    end
  end

  assign avail_o = avail_q[rd_r_i];

  // Entry memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_proc && res_ok && proc_ok) begin
      mem[wr_p][wr_r] <= {need_wr, req_i.allocation};
    end
    rd_data_q <= mem[rd_p_i][rd_r_i];
  end

  // Valid bits stand in for clearing the memory at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_proc && res_ok && proc_ok) begin
        valid_q[wr_p][wr_r] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_p_i][rd_r_i];
    end
  end

  // An entry never loaded reads as zero.
  assign need_o = rd_valid_q ? rd_data_q[2*ValW-1:ValW] : '0;
  assign held_o = rd_valid_q ? rd_data_q[ValW-1:0] : '0;

endmodule

### rtl/core/bsc_work_unit.sv
// ----------------------------------------------------------------------------
// Work vector unit
// Keeps the work vector and the one comparator and saturating adder that
// every resource step of the check shares.
// ----------------------------------------------------------------------------
module bsc_work_unit
  import bsc_pkg::*;
#(
  parameter int unsigned Resources = ResourcesDef,
  localparam int unsigned RIW = (Resources > 1) ? $clog2(Resources) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  wu_op_e          op_i,
  input  logic [RIW-1:0]  r_i,
  input  logic [ValW-1:0] avail_i,
  input  logic [ValW-1:0] need_i,
  input  logic [ValW-1:0] held_i,
  output logic            fit_o
);

  logic [WorkW-1:0] work_q [Resources];
  logic [WorkW:0]   sum;
  logic [WorkW-1:0] sum_sat;

  // Shared compare: does the need fit in the selected work entry.
  assign fit_o = WorkW'(need_i) <= work_q[r_i];

  // Shared adder, saturating at the top of the work range.
  assign sum     = {1'b0, work_q[r_i]} + (WorkW + 1)'(held_i);
  assign sum_sat = sum[WorkW] ? '1 : sum[WorkW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Resources; i++) begin
        work_q[i] <= '0;
      end
    end else begin
      case (op_i)
        WU_LOAD: work_q[r_i] <= WorkW'(avail_i);
        WU_ADD:  work_q[r_i] <= sum_sat;
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/bsc_seq.sv
// ----------------------------------------------------------------------------
// Safety check sequencer
// Accepts transactions, steps the sweeps one resource at a time, records
// the safe order and emits the results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bsc_seq
  import bsc_pkg::*;
#(
  parameter int unsigned Processes = ProcessesDef,
  parameter int unsigned Resources = ResourcesDef,
  localparam int unsigned PIW = (Processes > 1) ? $clog2(Processes) : 1,
  localparam int unsigned RIW = (Resources > 1) ? $clog2(Resources) : 1,
  localparam int unsigned CW  = $clog2(Processes + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  bsc_req_t       req_i,
  output logic           busy,
  output tbl_ctrl_t      tbl_ctrl_o,
  output logic [PIW-1:0] rd_p_o,
  output logic [RIW-1:0] rd_r_o,
  output wu_op_e         wu_op_o,
  input  logic           fit_i,
  output logic           result_valid_o,
  output bsc_rsp_t       rsp_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_INIT   = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_RD_CHK = 8'b0000_1000,
    S_EV_CHK = 8'b0001_0000,
    S_RD_ADD = 8'b0010_0000,
    S_EV_ADD = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_e;

  localparam logic [PIW-1:0] PLast = PIW'(Processes - 1);
  localparam logic [RIW-1:0] RLast = RIW'(Resources - 1);

  state_e               state_q, state_d;
  logic [PIW-1:0]       p_q, p_d;
  logic [RIW-1:0]       r_q, r_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [Processes-1:0] fin_q, fin_d;
  logic                 found_q, found_d;
  logic                 unsafe_q, unsafe_d;
  logic [PidW-1:0]      order_q [Processes];
  logic                 accept;
  logic                 adv;
  logic                 ord_we;
  logic                 last;

  // A transaction is taken only while idle.
  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  assign tbl_ctrl_o.wr_avail = accept && (req_i.opcode == OP_LOAD_AVAIL);
  assign tbl_ctrl_o.wr_proc  = accept && (req_i.opcode == OP_LOAD_PROC);

  // Tables are read at the current process and resource.
  assign rd_p_o = p_q;
  assign rd_r_o = r_q;

  assign last = unsafe_q || (p_q == PLast);

  // Next-state logic of the sweep sequencer.
  always_comb begin
    state_d  = state_q;
    p_d      = p_q;
    r_d      = r_q;
    cnt_d    = cnt_q;
    fin_d    = fin_q;
    found_d  = found_q;
    unsafe_d = unsafe_q;
    adv      = 1'b0;
    ord_we   = 1'b0;
    wu_op_o  = WU_IDLE;
    case (state_q)
      S_IDLE: begin
        if (accept && (req_i.opcode == OP_CHECK)) begin
          state_d = S_INIT;
          r_d     = '0;
          fin_d   = '0;
          cnt_d   = '0;
        end
      end
      S_INIT: begin
        wu_op_o = WU_LOAD;
        if (r_q == RLast) begin
          r_d     = '0;
          p_d     = '0;
          found_d = 1'b0;
          state_d = S_SCAN;
        end else begin
          r_d = r_q + RIW'(1);
        end
      end
      S_SCAN: begin
        if (fin_q[p_q]) begin
          adv = 1'b1;
        end else begin
          r_d     = '0;
          state_d = S_RD_CHK;
        end
      end
      S_RD_CHK: state_d = S_EV_CHK;
      S_EV_CHK: begin
        if (!fit_i) begin
          adv = 1'b1;
        end else if (r_q == RLast) begin
          r_d     = '0;
          state_d = S_RD_ADD;
        end else begin
          r_d     = r_q + RIW'(1);
          state_d = S_RD_CHK;
        end
      end
      S_RD_ADD: state_d = S_EV_ADD;
      S_EV_ADD: begin
        wu_op_o = WU_ADD;
        if (r_q == RLast) begin
          ord_we       = 1'b1;
          cnt_d        = cnt_q + CW'(1);
          fin_d[p_q]   = 1'b1;
          found_d      = 1'b1;
          adv          = 1'b1;
        end else begin
          r_d     = r_q + RIW'(1);
          state_d = S_RD_ADD;
        end
      end
      S_EMIT: begin
        if (last) begin
          state_d = S_IDLE;
        end else begin
          p_d = p_q + PIW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Move to the next process; at the end of a sweep decide the outcome.
    if (adv) begin
      if (p_q == PLast) begin
        p_d = '0;
        if (cnt_d == CW'(Processes)) begin
          unsafe_d = 1'b0;
          state_d  = S_EMIT;
        end else if (!found_d) begin
          unsafe_d = 1'b1;
          state_d  = S_EMIT;
        end else begin
          found_d = 1'b0;
          state_d = S_SCAN;
        end
      end else begin
        p_d     = p_q + PIW'(1);
        state_d = S_SCAN;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      p_q      <= '0;
      r_q      <= '0;
      cnt_q    <= '0;
      fin_q    <= '0;
      found_q  <= 1'b0;
      unsafe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      p_q      <= p_d;
      r_q      <= r_d;
      cnt_q    <= cnt_d;
      fin_q    <= fin_d;
      found_q  <= found_d;
      unsafe_q <= unsafe_d;
    end
  end

  // Safe order, written once per finished process.
  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      order_q[cnt_q[PIW-1:0]] <= PidW'(p_q);
    end
  end

  // Result transaction, one per cycle in the emit state.
  assign result_valid_o   = (state_q == S_EMIT);
  assign rsp_o.safe       = !unsafe_q;
  assign rsp_o.position   = unsafe_q ? '0 : PosW'(p_q);
  assign rsp_o.process_id = unsafe_q ? '0 : order_q[p_q];
  assign rsp_o.last       = last;

  `BSC_ASSERT(a_result_only_busy, result_valid_o |-> busy, "result outside a check")
  `BSC_ASSERT(a_check_goes_busy, (accept && (req_i.opcode == OP_CHECK)) |=> busy,
              "check transaction did not start")
  `BSC_ASSERT(a_last_ends_check, (result_valid_o && rsp_o.last) |=> !busy,
              "check did not end after its last result")
  `BSC_ASSERT(a_safe_results_run, (result_valid_o && !rsp_o.last) |=> result_valid_o,
              "gap in safe order results")
  `BSC_ASSERT_ALWAYS(a_count_bound, cnt_q <= CW'(Processes), "order count overflow")

endmodule

### rtl/core/bankers_safety_check_core.sv
// ----------------------------------------------------------------------------
// Banker's algorithm safety check core
// Loads do not raise busy; while no check runs, a load can follow every cycle.
// A check first loads the work vector resource by resource, then in each sweep
// reads and evaluates every process through the shared work unit, up to P sweeps.
// Results follow as P back-to-back results (a single one when unsafe); no stall.
// Reset clears the available table, the entry valid bits and the work vector; the core comes up idle.
// ----------------------------------------------------------------------------
module bankers_safety_check_core
  import bsc_pkg::*;
#(
  parameter int unsigned Processes = ProcessesDef,
  parameter int unsigned Resources = ResourcesDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  bsc_req_t req_i,
  output logic     busy,
  output logic     result_valid_o,
  output bsc_rsp_t rsp_o
);

  localparam int unsigned PIW = (Processes > 1) ? $clog2(Processes) : 1;
  localparam int unsigned RIW = (Resources > 1) ? $clog2(Resources) : 1;

  tbl_ctrl_t       tbl_ctrl;
  logic [PIW-1:0]  rd_p;
  logic [RIW-1:0]  rd_r;
  logic [ValW-1:0] avail;
  logic [ValW-1:0] need;
  logic [ValW-1:0] held;
  wu_op_e          wu_op;
  logic            fit;

  // Sequencer: transaction handshake, sweeps and result output.
  bsc_seq #(
    .Processes(Processes),
    .Resources(Resources)
  ) u_seq (
    .clk_i,
    .rst_ni,
    .start,
    .req_i,
    .busy,
    .tbl_ctrl_o    (tbl_ctrl),
    .rd_p_o        (rd_p),
    .rd_r_o        (rd_r),
    .wu_op_o       (wu_op),
    .fit_i         (fit),
    .result_valid_o,
    .rsp_o
  );

  // Available, need and allocation tables.
  bsc_tables #(
    .Processes(Processes),
    .Resources(Resources)
  ) u_tables (
    .clk_i,
    .rst_ni,
    .ctrl_i  (tbl_ctrl),
    .req_i,
    .rd_p_i  (rd_p),
    .rd_r_i  (rd_r),
    .avail_o (avail),
    .need_o  (need),
    .held_o  (held)
  );

  // Work vector with the shared compare and add.
  bsc_work_unit #(
    .Resources(Resources)
  ) u_work (
    .clk_i,
    .rst_ni,
    .op_i    (wu_op),
    .r_i     (rd_r),
    .avail_i (avail),
    .need_i  (need),
    .held_i  (held),
    .fit_o   (fit)
  );

endmodule

### bench/tb_bankers_safety_check_core.sv
// ----------------------------------------------------------------------------
// Safety check core testbench
// Drives load and check commands into the core with random idle gaps. A
// tracker class keeps its own copy of the tables, works out the safe order
// or the unsafe verdict for every accepted check, and compares each result
// transaction field by field against the oldest expected one.
// ----------------------------------------------------------------------------
module tb_bankers_safety_check_core;
  import bsc_pkg::*;

  localparam int unsigned Procs = ProcessesDef;
  localparam int unsigned Res = ResourcesDef;
  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam logic [WorkW-1:0] WorkCeil = {WorkW{1'b1}};
  localparam int unsigned ItemTarget = 350;
  localparam int unsigned SettleCycles = 1200;
  localparam int unsigned TimeLimit = 5_000_000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  bsc_req_t req_i = '0;
  logic     busy;
  logic     result_valid_o;
  bsc_rsp_t rsp_o;

  // Tracks the tables and the expected results of every accepted check.
  class safe_order_tracker;
    logic [ValW-1:0] avail_tbl [Res];
    logic [ValW-1:0] demand_tbl [Procs][Res];
    logic [ValW-1:0] held_tbl [Procs][Res];
    bsc_rsp_t        order_due [$];
    int unsigned     errors;
    int unsigned     results;
    int unsigned     commands;
    int unsigned     ignored;
    int unsigned     safe_checks;
    int unsigned     unsafe_checks;

    function new();
      foreach (avail_tbl[r]) avail_tbl[r] = '0;
      foreach (demand_tbl[p, r]) begin
        demand_tbl[p][r] = '0;
        held_tbl[p][r] = '0;
      end
      errors = 0;
      results = 0;
      commands = 0;
      ignored = 0;
      safe_checks = 0;
      unsafe_checks = 0;
    endfunction

    function int unsigned pending();
      return order_due.size();
    endfunction

    // Sweeps the processes in index order until all finish or a sweep stalls.
    function void plan_order();
      logic [WorkW-1:0] work [Res];
      logic [WorkW:0]   total;
      logic [ValW-1:0]  need;
      logic [PidW-1:0]  order [Procs];
      bit               done [Procs];
      bit               progress;
      bit               fits;
      int unsigned      count;
      bsc_rsp_t         rsp;
      foreach (work[r]) work[r] = {{(WorkW-ValW){1'b0}}, avail_tbl[r]};
      foreach (done[p]) done[p] = 1'b0;
      count = 0;
      do begin
        progress = 1'b0;
        for (int p = 0; p < Procs; p++) begin
          if (!done[p]) begin
            fits = 1'b1;
            for (int r = 0; r < Res; r++) begin
              need = (demand_tbl[p][r] > held_tbl[p][r]) ?
                     demand_tbl[p][r] - held_tbl[p][r] : '0;
              if ({{(WorkW-ValW){1'b0}}, need} > work[r]) fits = 1'b0;
            end
            if (fits) begin
              // A finished process hands its allocation back to the pool.
              for (int r = 0; r < Res; r++) begin
                total = {1'b0, work[r]} + {{(WorkW-ValW+1){1'b0}}, held_tbl[p][r]};
                work[r] = (total > {1'b0, WorkCeil}) ? WorkCeil : total[WorkW-1:0];
              end
              order[count] = p[PidW-1:0];
              count++;
              done[p] = 1'b1;
              progress = 1'b1;
            end
          end
        end
      end while (progress && count < Procs);

      if (count == Procs) begin
        safe_checks++;
        for (int pos = 0; pos < Procs; pos++) begin
          rsp.safe = 1'b1;
          rsp.position = pos[PosW-1:0];
          rsp.process_id = order[pos];
          rsp.last = (pos == Procs - 1);
          order_due.push_back(rsp);
        end
      end else begin
        unsafe_checks++;
        rsp = '0;
        rsp.last = 1'b1;
        order_due.push_back(rsp);
      end
    endfunction

    // Applies one accepted command transaction.
    function void accept_cmd(bsc_req_t cmd);
      commands++;
      case (cmd.opcode)
        OP_LOAD_AVAIL: avail_tbl[cmd.resource_index] = cmd.available_amount;
        OP_LOAD_PROC: begin
          demand_tbl[cmd.process_index][cmd.resource_index] = cmd.max_demand;
          held_tbl[cmd.process_index][cmd.resource_index] = cmd.allocation;
        end
        OP_CHECK: plan_order();
        default: ignored++;
      endcase
    endfunction

    // Compares one result transaction with the oldest expected one.
    function void match_result(bsc_rsp_t got);
      bsc_rsp_t want;
      if (order_due.size() == 0) begin
        $display("%0t: unexpected result: safe=%0b position=%0d process_id=%0d last=%0b",
                 $time, got.safe, got.position, got.process_id, got.last);
        errors++;
        return;
      end
      want = order_due.pop_front();
      results++;
      if (got.safe !== want.safe) begin
        $display("%0t: safe mismatch: expected %0b, actual %0b", $time, want.safe, got.safe);
        errors++;
      end
      if (got.position !== want.position) begin
        $display("%0t: position mismatch: expected %0d, actual %0d",
                 $time, want.position, got.position);
        errors++;
      end
      if (got.process_id !== want.process_id) begin
        $display("%0t: process_id mismatch: expected %0d, actual %0d",
                 $time, want.process_id, got.process_id);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  safe_order_tracker tracker = new;
  int unsigned       sent = 0;
  bit                steady = 1'b0;

  bankers_safety_check_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .req_i          (req_i),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Observes accepted commands and result strobes at each rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) tracker.accept_cmd(req_i);
      if (result_valid_o) tracker.match_result(rsp_o);
    end
  end

  // Idle gaps: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [ValW-1:0] pick_amount(int unsigned ceiling);
    logic [31:0] v;
    v = $urandom_range(ceiling, 0);
    return v[ValW-1:0];
  endfunction

  function automatic int unsigned pick_ceiling();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 65) return 12;
    if (roll < 85) return 300;
    return 65535;
  endfunction

  // Every field random; callers overwrite the fields that matter.
  function automatic bsc_req_t scrambled_cmd();
    logic [31:0] lo;
    logic [31:0] hi;
    bsc_req_t    cmd;
    lo = $urandom;
    hi = $urandom;
    cmd.opcode = lo[1:0];
    cmd.process_index = lo[4:2];
    cmd.resource_index = lo[6:5];
    cmd.available_amount = lo[31:16];
    cmd.max_demand = hi[15:0];
    cmd.allocation = hi[31:16];
    return cmd;
  endfunction

  function automatic bsc_req_t avail_cmd(logic [RidW-1:0] rid, logic [ValW-1:0] amount);
    bsc_req_t cmd;
    cmd = scrambled_cmd();
    cmd.opcode = OP_LOAD_AVAIL;
    cmd.resource_index = rid;
    cmd.available_amount = amount;
    return cmd;
  endfunction

  function automatic bsc_req_t proc_cmd(logic [PidW-1:0] pid, logic [RidW-1:0] rid,
                                        logic [ValW-1:0] dem, logic [ValW-1:0] held);
    bsc_req_t cmd;
    cmd = scrambled_cmd();
    cmd.opcode = OP_LOAD_PROC;
    cmd.process_index = pid;
    cmd.resource_index = rid;
    cmd.max_demand = dem;
    cmd.allocation = held;
    return cmd;
  endfunction

  function automatic bsc_req_t check_cmd();
    bsc_req_t cmd;
    cmd = scrambled_cmd();
    cmd.opcode = OP_CHECK;
    return cmd;
  endfunction

  // Presents one command until it is taken, then maybe idles.
  task automatic issue(input bsc_req_t cmd);
    int unsigned idle;
    start <= 1'b1;
    req_i <= cmd;
    if (cmd.opcode != OpUnused) sent++;
    do @(posedge clk_i); while (busy !== 1'b0);
    idle = steady ? 0 : pick_gap();
    if (idle != 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
  endtask

  // Holds off the sender until every expected result has arrived.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    bsc_req_t    cmd;
    int unsigned roll;
    int unsigned ceiling;
    logic [31:0] pick;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Check straight after reset: every need is zero, order is 0 to 7.
    issue(check_cmd());
    // Unused opcode with every field bit set is dropped.
    cmd = '1;
    issue(cmd);
    // Full-scale need that just fits, and allocation above maximum demand.
    issue(avail_cmd(2'd3, 16'hFFFF));
    issue(proc_cmd(3'd7, 2'd3, 16'hFFFF, 16'h0000));
    issue(proc_cmd(3'd0, 2'd0, 16'h0000, 16'hFFFF));
    issue(check_cmd());
    // A need nobody can ever cover makes the system unsafe.
    issue(proc_cmd(3'd2, 2'd1, 16'hFFFF, 16'h0000));
    settle();
    issue(check_cmd());
    // Reverse chain: each sweep frees exactly one process, highest index first.
    for (int p = 0; p < Procs; p++)
      issue(proc_cmd(p[PidW-1:0], 2'd1, 16'(8 - p), 16'd1));
    issue(check_cmd());
    // Largest amounts everywhere in use.
    issue(avail_cmd(2'd0, 16'hFFFF));
    issue(avail_cmd(2'd1, 16'hFFFF));
    issue(proc_cmd(3'd5, 2'd2, 16'hFFFF, 16'hFFFF));
    issue(check_cmd());

    // Random phases, mostly table updates followed by a check.
    while (sent < ItemTarget) begin
      roll = $urandom_range(99, 0);
      steady = ($urandom_range(3, 0) == 0);
      ceiling = pick_ceiling();
      if (roll < 62) begin
        for (int r = 0; r < Res; r++)
          if ($urandom_range(1, 0) == 1) issue(avail_cmd(r[RidW-1:0], pick_amount(ceiling)));
        repeat ($urandom_range(8, 1)) begin
          pick = $urandom;
          issue(proc_cmd(pick[PidW-1:0], pick[PidW+RidW-1:PidW],
                         pick_amount(ceiling), pick_amount(ceiling)));
        end
        if ($urandom_range(11, 0) == 0) settle();
        issue(check_cmd());
      end else if (roll < 68) begin
        // Whole table rewrite.
        for (int r = 0; r < Res; r++) issue(avail_cmd(r[RidW-1:0], pick_amount(ceiling)));
        for (int p = 0; p < Procs; p++)
          for (int r = 0; r < Res; r++)
            issue(proc_cmd(p[PidW-1:0], r[RidW-1:0],
                           pick_amount(ceiling), pick_amount(ceiling)));
        issue(check_cmd());
      end else if (roll < 88) begin
        // Noise over the full field ranges, unused opcode included.
        repeat ($urandom_range(6, 1)) issue(scrambled_cmd());
      end else begin
        issue(check_cmd());
        issue(check_cmd());
      end
    end

    // Drain, then watch for strays for the length of a worst-case check.
    settle();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Run covered %0d commands (%0d with the unused opcode) and %0d checks:",
             tracker.commands, tracker.ignored, tracker.safe_checks + tracker.unsafe_checks);
    $display("  %0d safe, %0d unsafe, %0d results compared, %0d mismatches.",
             tracker.safe_checks, tracker.unsafe_checks, tracker.results, tracker.errors);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb_bankers_safety_check_core: done, clean");
    end else begin
      $display("tb_bankers_safety_check_core: done, errors");
    end
    $finish;
  end

  // Hard stop in case the core hangs.
  initial begin
    #(TimeLimit);
    $display("tb_bankers_safety_check_core: done, errors");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/bsc_pkg.sv
rtl/core/bsc_tables.sv
rtl/core/bsc_work_unit.sv
rtl/core/bsc_seq.sv
rtl/core/bankers_safety_check_core.sv
bench/tb_bankers_safety_check_core.sv
